>>> design/fbpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpc_pkg
// Types and constants shared by the frustum box/point culler modules.
// ----------------------------------------------------------------------------
package fbpc_pkg;

	localparam int GRID_W  = 24;   // input coordinates and camera position
	localparam int COEF_W  = 32;   // plane coefficient, signed fixed point
	localparam int COORD_W = 35;   // widest corner coordinate (grid * 1000 + 1150)
	localparam int PROD_W  = COEF_W + COORD_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int DIST_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * GRID_W;
	localparam int LIMIT_W = 48;
	localparam int CFG_W   = 48;

	// grid cube geometry
	localparam int CUBE_PITCH  = 1000;
	localparam int CUBE_MARGIN = 150;
	localparam int CUBE_SIZE   = 1300;
	localparam int CUBE_HI_OFS = CUBE_SIZE - CUBE_MARGIN;
	localparam int CUBE_HALF   = 500;
	localparam int SPECIAL_X   = -16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16000000);

	typedef enum logic [2:0] {
		OP_LOAD      = 3'd0,
		OP_BOX       = 3'd1,
		OP_POINT     = 3'd2,
		OP_CUBE      = 3'd3,
		OP_CUBE_DIST = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_CAM_X = 2'd0,
		REG_CAM_Y = 2'd1,
		REG_CAM_Z = 2'd2,
		REG_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		COEF_A = 2'd0,
		COEF_B = 2'd1,
		COEF_C = 2'd2,
		COEF_D = 2'd3
	} coef_t;

	// item as it arrives at the input port
	typedef struct packed {
		op_t                          op;
		logic [1:0]                   plane_index;
		logic [1:0]                   coef_index;
		logic [COEF_W-1:0]            coef_value;
		logic [2:0][GRID_W-1:0]       lo;
		logic [2:0][GRID_W-1:0]       hi;
	} in_item_t;

	// item travelling down the plane cells
	typedef struct packed {
		op_t                          op;
		logic [1:0]                   plane_index;
		logic [1:0]                   coef_index;
		logic [COEF_W-1:0]            coef_value;
		logic [2:0][COORD_W-1:0]      mn;        // per-axis smaller corner coord
		logic [2:0][COORD_W-1:0]      mx;        // per-axis larger corner coord
		logic                         x_special; // grid x is the always-visible column
		logic                         far;       // beyond distance limit
		logic                         cull;      // some plane has all corners >= 0
		logic                         pout;      // point lies > 0 on some plane
	} item_t;

endpackage

`default_nettype wire

>>> design/fbpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpc_front
// Three-stage front end: corner coordinates, camera distance squares, and
// the distance-limit compare.
// ----------------------------------------------------------------------------
module fbpc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire fbpc_pkg::in_item_t            in_item,
	input  wire logic [2:0][fbpc_pkg::GRID_W-1:0] cam,
	input  wire logic [fbpc_pkg::LIMIT_W-1:0]  limit,
	output logic                               out_valid,
	output fbpc_pkg::item_t                    out_item
);
	import fbpc_pkg::*;

	item_t                   item_c;
	logic [2:0][GRID_W-1:0]  mag_c;
	logic                    big_c;

	logic signed [GRID_W-1:0]  lo_s;
	logic signed [GRID_W-1:0]  hi_s;
	logic signed [GRID_W-1:0]  cam_s;
	logic signed [COORD_W-1:0] g1000;
	logic signed [COORD_W-1:0] cube_lo;
	logic signed [COORD_W-1:0] cube_hi;
	logic signed [DIST_W-1:0]  dist_c;
	logic [DIST_W-1:0]         dist_abs;

	// stage registers
	logic                    v_s1, v_s2, v_s3;
	item_t                   item_s1, item_s2, item_s3;
	logic [2:0][GRID_W-1:0]  mag_s1;
	logic                    big_s1, big_s2;
	logic [2:0][SQ_W-1:0]    sq_s2;
	item_t                   item_far_c;

	always_comb begin
		item_c             = '0;
		item_c.op          = in_item.op;
		item_c.plane_index = in_item.plane_index;
		item_c.coef_index  = in_item.coef_index;
		item_c.coef_value  = in_item.coef_value;
		item_c.x_special   = ($signed(in_item.lo[0]) == GRID_W'(SPECIAL_X));
		big_c              = 1'b0;
		mag_c              = '0;
		lo_s = '0; hi_s = '0; cam_s = '0; g1000 = '0; cube_lo = '0; cube_hi = '0;
		dist_c = '0; dist_abs = '0;
		for (int i = 0; i < 3; i++) begin
			lo_s    = $signed(in_item.lo[i]);
			hi_s    = $signed(in_item.hi[i]);
			cam_s   = $signed(cam[i]);
			g1000   = COORD_W'(lo_s) * COORD_W'(CUBE_PITCH);
			cube_lo = g1000 - COORD_W'(CUBE_MARGIN);
			cube_hi = g1000 + COORD_W'(CUBE_HI_OFS);
			case (in_item.op)
				OP_CUBE, OP_CUBE_DIST: begin
					item_c.mn[i] = cube_lo;
					item_c.mx[i] = cube_hi;
				end
				OP_BOX: begin
					// the minimum over corners picks per axis, whatever order lo/hi are in
					if (lo_s <= hi_s) begin
						item_c.mn[i] = COORD_W'(lo_s);
						item_c.mx[i] = COORD_W'(hi_s);
					end else begin
						item_c.mn[i] = COORD_W'(hi_s);
						item_c.mx[i] = COORD_W'(lo_s);
					end
				end
				default: begin
					item_c.mn[i] = COORD_W'(lo_s);
					item_c.mx[i] = COORD_W'(lo_s);
				end
			endcase
			// offset from camera to cube centre
			dist_c   = DIST_W'(g1000) + DIST_W'(CUBE_HALF) - DIST_W'(cam_s);
			dist_abs = dist_c[DIST_W-1] ? DIST_W'(-dist_c) : dist_c;
			if (|dist_abs[DIST_W-1:GRID_W])
				big_c = 1'b1;
			mag_c[i] = dist_abs[GRID_W-1:0];
		end
	end

	always_comb begin
		item_far_c     = item_s2;
		item_far_c.far = big_s2 ||
			((SQ_W+2)'(sq_s2[0]) + (SQ_W+2)'(sq_s2[1]) + (SQ_W+2)'(sq_s2[2])
			 > (SQ_W+2)'(limit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_c;
			mag_s1  <= mag_c;
			big_s1  <= big_c;

			item_s2 <= item_s1;
			big_s2  <= big_s1;
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);

			item_s3 <= item_far_c;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

>>> design/fbpc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpc_cell
// One plane: holds its four coefficients, evaluates the plane at the item's
// nearest corner in two stages, and passes the item to the next cell.
// ----------------------------------------------------------------------------
module fbpc_cell #(
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire fbpc_pkg::item_t in_item,
	output logic                 out_valid,
	output fbpc_pkg::item_t      out_item
);
	import fbpc_pkg::*;

	localparam logic [3:0] IDX_L = 4'(IDX);

	logic [COEF_W-1:0]               coef_q [4];
	logic                            v_s1, v_s2;
	item_t                           item_s1, item_s2;
	logic signed [2:0][PROD_W-1:0]   prod_s1;
	logic signed [COEF_W-1:0]        dcoef_s1;
	logic signed [SUM_W-1:0]         sum;
	logic                            load_hit;
	item_t                           item_flag_c;

	assign load_hit = en && in_valid && (in_item.op == OP_LOAD) &&
	                  ({2'b00, in_item.plane_index} == IDX_L);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				coef_q[k] <= '0;
		end else if (load_hit) begin
			coef_q[in_item.coef_index] <= in_item.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: per-axis product at the corner that minimizes the plane value
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= in_item;
			dcoef_s1 <= $signed(coef_q[COEF_D]);
			for (int i = 0; i < 3; i++) begin
				if (coef_q[i][COEF_W-1])
					prod_s1[i] <= PROD_W'($signed(coef_q[i])) * PROD_W'($signed(in_item.mx[i]));
				else
					prod_s1[i] <= PROD_W'($signed(coef_q[i])) * PROD_W'($signed(in_item.mn[i]));
			end
		end
	end

	assign sum = SUM_W'($signed(prod_s1[0])) + SUM_W'($signed(prod_s1[1])) +
	             SUM_W'($signed(prod_s1[2])) + SUM_W'(dcoef_s1);

	// box culls on >= 0, point leaves on > 0
	always_comb begin
		item_flag_c      = item_s1;
		item_flag_c.cull = item_s1.cull | ~sum[SUM_W-1];
		item_flag_c.pout = item_s1.pout | (~sum[SUM_W-1] & (|sum));
	end

	// stage 2: sign of the plane value
	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_flag_c;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

>>> design/frustum_box_point_culler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_box_point_culler_core
// Frustum culler for boxes, points and grid cubes against side planes.
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_stall is low and returns exactly one
// result per item, in order. An item passes a three-stage front end (corner
// coordinates, camera distance squares, distance-limit compare), then a row
// of NUM_PLANES plane cells of two stages each (one multiplier per axis, then
// a sum and sign test), then the output register. Coefficient loads
// ride the same row and are written as they pass their plane's cell, so
// every later item sees them. A two-entry output (register plus skid) lets
// the row keep moving while a result waits; in_stall rises only once the
// skid entry is taken, and falls the cycle after out_stall drops.
// Configuration (camera position, squared distance limit) must be written
// only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module frustum_box_point_culler_core #(
	parameter int NUM_PLANES = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [fbpc_pkg::CFG_W-1:0]    cfg_data,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    operation,
	input  wire logic [1:0]                    plane_index,
	input  wire logic [1:0]                    coef_index,
	input  wire logic signed [31:0]            coef_value,
	input  wire logic signed [23:0]            lo_x,
	input  wire logic signed [23:0]            lo_y,
	input  wire logic signed [23:0]            lo_z,
	input  wire logic signed [23:0]            hi_x,
	input  wire logic signed [23:0]            hi_y,
	input  wire logic signed [23:0]            hi_z,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               verdict,
	output logic                               far_culled
);
	import fbpc_pkg::*;

	// configuration registers
	logic [2:0][GRID_W-1:0] cam_q;
	logic [LIMIT_W-1:0]     limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q   <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CAM_X: cam_q[0] <= cfg_data[GRID_W-1:0];
				REG_CAM_Y: cam_q[1] <= cfg_data[GRID_W-1:0];
				REG_CAM_Z: cam_q[2] <= cfg_data[GRID_W-1:0];
				REG_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				default:   ;
			endcase
		end
	end

	// pipeline advances whenever the skid entry is free
	logic      skid_valid_q;
	logic      en;
	in_item_t  in_item;

	assign en       = ~skid_valid_q;
	assign in_stall = skid_valid_q;

	always_comb begin
		in_item.op          = op_t'(operation);
		in_item.plane_index = plane_index;
		in_item.coef_index  = coef_index;
		in_item.coef_value  = coef_value;
		in_item.lo          = {lo_z, lo_y, lo_x};
		in_item.hi          = {hi_z, hi_y, hi_x};
	end

	logic  chain_v    [NUM_PLANES+1];
	item_t chain_item [NUM_PLANES+1];

	fbpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.cam       (cam_q),
		.limit     (limit_q),
		.out_valid (chain_v[0]),
		.out_item  (chain_item[0])
	);

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
		fbpc_cell #(.IDX(p)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[p]),
			.in_item   (chain_item[p]),
			.out_valid (chain_v[p+1]),
			.out_item  (chain_item[p+1])
		);
	end

	// final verdict from the accumulated plane flags
	item_t last;
	logic  verdict_c;
	logic  far_c;

	assign last = chain_item[NUM_PLANES];

	always_comb begin
		verdict_c = 1'b0;
		far_c     = 1'b0;
		case (last.op)
			OP_BOX, OP_CUBE: verdict_c = ~last.cull;
			OP_POINT:        verdict_c = ~last.pout;
			OP_CUBE_DIST: begin
				if (last.x_special)
					verdict_c = 1'b1;
				else if (last.far)
					far_c = 1'b1;
				else
					verdict_c = ~last.cull;
			end
			default: ;
		endcase
	end

	// output register plus skid entry
	logic skid_verdict_q;
	logic skid_far_q;
	logic out_valid_q;
	logic verdict_q;
	logic far_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall)
				skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= chain_v[NUM_PLANES];
		end else if (chain_v[NUM_PLANES]) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				verdict_q <= skid_verdict_q;
				far_q     <= skid_far_q;
			end
		end else if (!out_valid_q || !out_stall) begin
			verdict_q <= verdict_c;
			far_q     <= far_c;
		end else begin
			skid_verdict_q <= verdict_c;
			skid_far_q     <= far_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign far_culled = far_q;

endmodule

`default_nettype wire
